### design/vsrt_pkg.sv
`default_nettype none

package vsrt_pkg;

  localparam int SPRITE_BYTES = 256;

  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam logic [2:0] REG_CTRL     = 3'd0;
  localparam logic [2:0] REG_MASK     = 3'd1;
  localparam logic [2:0] REG_STATUS   = 3'd2;
  localparam logic [2:0] REG_SPR_ADDR = 3'd3;
  localparam logic [2:0] REG_SPR_DATA = 3'd4;
  localparam logic [2:0] REG_SCROLL   = 3'd5;
  localparam logic [2:0] REG_ADDR     = 3'd6;
  localparam logic [2:0] REG_DATA     = 3'd7;

  localparam logic [8:0] DOT_LAST     = 9'd340;
  localparam logic [8:0] LINE_LAST    = 9'd261;
  localparam logic [8:0] LINE_VBLANK  = 9'd241;
  localparam logic [8:0] LINE_VISIBLE = 9'd240;

  typedef struct packed {
    logic [7:0]  read_data;
    logic [13:0] vram_addr;
    logic        vram_write;
    logic        vram_read;
    logic [7:0]  vram_wdata;
    logic        nmi;
    logic [2:0]  fine_x;
    logic [8:0]  line_num;
    logic [8:0]  dot_num;
    logic        spr_rd;
  } res_t;

  typedef struct packed {
    logic       we;
    logic       re;
    logic [7:0] addr;
    logic [7:0] wdata;
  } spr_req_t;

endpackage

`default_nettype wire

### design/vsrt_if.sv
`default_nettype none

interface vsrt_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [2:0] reg_sel;
  logic [7:0] wdata;

  modport source (output valid, cmd, reg_sel, wdata, input ready);
  modport sink   (input valid, cmd, reg_sel, wdata, output ready);
endinterface

interface vsrt_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  read_data;
  logic [13:0] vram_addr;
  logic        vram_write;
  logic        vram_read;
  logic [7:0]  vram_wdata;
  logic        nmi;
  logic [2:0]  fine_x;
  logic [8:0]  line_num;
  logic [8:0]  dot_num;

  modport source (output valid, read_data, vram_addr, vram_write, vram_read, vram_wdata,
                  nmi, fine_x, line_num, dot_num, input ready);
  modport sink   (input valid, read_data, vram_addr, vram_write, vram_read, vram_wdata,
                  nmi, fine_x, line_num, dot_num, output ready);
endinterface

`default_nettype wire

### design/vsrt_ram.sv
`default_nettype none

module vsrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

### design/vsrt_spr.sv
`default_nettype none

module vsrt_spr #(
  parameter int SPRITE_BYTES = vsrt_pkg::SPRITE_BYTES
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire vsrt_pkg::spr_req_t  req,
  output logic [7:0]               rdata
);

  localparam int AW = $clog2(SPRITE_BYTES);

  logic [SPRITE_BYTES-1:0] valid_r;
  logic                    vld_rd_r;
  logic [7:0]              ram_q;
  logic [AW-1:0]           idx;

  assign idx = req.addr[AW-1:0];

  vsrt_ram #(
    .WIDTH (8),
    .DEPTH (SPRITE_BYTES)
  ) u_ram (
    .clk   (clk),
    .we    (req.we),
    .waddr (idx),
    .wdata (req.wdata),
    .re    (req.re),
    .raddr (idx),
    .rdata (ram_q)
  );

  // An entry never written since reset reads as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      vld_rd_r <= 1'b0;
    end else begin
      if (req.we) begin
        valid_r[idx] <= 1'b1;
      end
      if (req.re) begin
        vld_rd_r <= valid_r[idx];
      end
    end
  end

  assign rdata = vld_rd_r ? ram_q : 8'd0;

endmodule

`default_nettype wire

### design/vsrt_ctrl.sv
`default_nettype none

module vsrt_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               fire,
  input  wire logic [1:0]         cmd,
  input  wire logic [2:0]         reg_sel,
  input  wire logic [7:0]         wdata,
  output vsrt_pkg::res_t          res,
  output vsrt_pkg::spr_req_t      spr_req
);

  localparam logic [14:0] HORZ_MASK = 15'h041F;
  localparam logic [14:0] VERT_MASK = 15'h7BE0;
  localparam logic [4:0]  ROW_LAST  = 5'd29;
  localparam logic [4:0]  ROW_MAX   = 5'd31;

  logic [15:0] cur_addr_r, cur_addr_nxt;
  logic [14:0] tmp_addr_r, tmp_addr_nxt;
  logic [2:0]  fine_r, fine_nxt;
  logic        second_r, second_nxt;
  logic [7:0]  ctrl_r, ctrl_nxt;
  logic [7:0]  mask_r, mask_nxt;
  logic [2:0]  status_r, status_nxt;
  logic [7:0]  sprite_ptr_r, sprite_ptr_nxt;
  logic [8:0]  dot_r, dot_nxt;
  logic [8:0]  line_r, line_nxt;
  logic        odd_r, odd_nxt;

  logic        drawing;
  logic        render_line;
  logic        fetch;
  logic [15:0] addr_col;
  logic [15:0] addr_row;
  logic [15:0] addr_tick;
  logic [15:0] addr_step;

  function automatic logic [15:0] step_column(input logic [15:0] a);
    logic [15:0] b;
    b = a;
    if (a[4:0] == 5'h1F) begin
      b[4:0] = 5'd0;
      b[10]  = ~a[10];
    end else begin
      b = a + 16'd1;
    end
    return b;
  endfunction

  function automatic logic [15:0] step_row(input logic [15:0] a);
    logic [15:0] b;
    logic [4:0]  row;
    b   = a;
    row = a[9:5];
    if (a[14:12] != 3'b111) begin
      b = a + 16'h1000;
    end else begin
      b[14:12] = 3'd0;
      if (row == ROW_LAST) begin
        row   = 5'd0;
        b[11] = ~a[11];
      end else if (row == ROW_MAX) begin
        row = 5'd0;
      end else begin
        row = row + 5'd1;
      end
      b[9:5] = row;
    end
    return b;
  endfunction

  assign drawing     = |mask_r[4:3];
  assign render_line = drawing && ((line_r < vsrt_pkg::LINE_VISIBLE) ||
                                   (line_r == vsrt_pkg::LINE_LAST));
  assign addr_step   = cur_addr_r + (ctrl_r[2] ? 16'd32 : 16'd1);

  always_comb begin
    case (dot_r) inside
      [9'd1:9'd256], [9'd321:9'd336]: fetch = 1'b1;
      default:                        fetch = 1'b0;
    endcase
  end

  always_comb begin
    addr_col  = (fetch && dot_r[2:0] == 3'd0) ? step_column(cur_addr_r) : cur_addr_r;
    addr_row  = (dot_r == 9'd256) ? step_row(addr_col) : addr_col;
    addr_tick = addr_row;
    if (dot_r == 9'd257) begin
      addr_tick = (addr_row & ~{1'b0, HORZ_MASK}) | {1'b0, tmp_addr_r & HORZ_MASK};
    end
    if (line_r == vsrt_pkg::LINE_LAST && dot_r >= 9'd280 && dot_r <= 9'd304) begin
      addr_tick = (addr_row & ~{1'b0, VERT_MASK}) | {1'b0, tmp_addr_r & VERT_MASK};
    end
  end

  always_comb begin
    cur_addr_nxt   = cur_addr_r;
    tmp_addr_nxt   = tmp_addr_r;
    fine_nxt       = fine_r;
    second_nxt     = second_r;
    ctrl_nxt       = ctrl_r;
    mask_nxt       = mask_r;
    status_nxt     = status_r;
    sprite_ptr_nxt = sprite_ptr_r;
    dot_nxt        = dot_r;
    line_nxt       = line_r;
    odd_nxt        = odd_r;
    res            = '0;
    spr_req        = '0;
    spr_req.addr   = sprite_ptr_r;
    spr_req.wdata  = wdata;

    case (cmd)
      vsrt_pkg::CMD_TICK: begin
        if (render_line) begin
          cur_addr_nxt = addr_tick;
        end
        if (line_r == vsrt_pkg::LINE_VBLANK && dot_r == 9'd1) begin
          status_nxt[2] = 1'b1;
          res.nmi       = ctrl_r[7];
        end
        if (line_r == vsrt_pkg::LINE_LAST && dot_r == 9'd1) begin
          status_nxt = 3'd0;
        end
        if (dot_r >= vsrt_pkg::DOT_LAST) begin
          dot_nxt = 9'd0;
          if (line_r >= vsrt_pkg::LINE_LAST) begin
            line_nxt = 9'd0;
            odd_nxt  = ~odd_r;
            if (!odd_r && drawing) begin
              dot_nxt = 9'd1;
            end
          end else begin
            line_nxt = line_r + 9'd1;
          end
        end else begin
          dot_nxt = dot_r + 9'd1;
        end
      end
      vsrt_pkg::CMD_WRITE: begin
        case (reg_sel)
          vsrt_pkg::REG_CTRL: begin
            ctrl_nxt            = wdata;
            tmp_addr_nxt[11:10] = wdata[1:0];
          end
          vsrt_pkg::REG_MASK: begin
            mask_nxt = wdata;
          end
          vsrt_pkg::REG_SPR_ADDR: begin
            sprite_ptr_nxt = wdata;
          end
          vsrt_pkg::REG_SPR_DATA: begin
            spr_req.we     = fire;
            sprite_ptr_nxt = sprite_ptr_r + 8'd1;
          end
          vsrt_pkg::REG_SCROLL: begin
            if (!second_r) begin
              tmp_addr_nxt[4:0] = wdata[7:3];
              fine_nxt          = wdata[2:0];
            end else begin
              tmp_addr_nxt[9:5]   = wdata[7:3];
              tmp_addr_nxt[14:12] = wdata[2:0];
            end
            second_nxt = ~second_r;
          end
          vsrt_pkg::REG_ADDR: begin
            if (!second_r) begin
              tmp_addr_nxt[14]   = 1'b0;
              tmp_addr_nxt[13:8] = wdata[5:0];
            end else begin
              tmp_addr_nxt[7:0] = wdata;
              cur_addr_nxt      = {1'b0, tmp_addr_r[14:8], wdata};
            end
            second_nxt = ~second_r;
          end
          vsrt_pkg::REG_DATA: begin
            res.vram_addr  = cur_addr_r[13:0];
            res.vram_write = 1'b1;
            res.vram_wdata = wdata;
            cur_addr_nxt   = addr_step;
          end
          default: begin
          end
        endcase
      end
      vsrt_pkg::CMD_READ: begin
        case (reg_sel)
          vsrt_pkg::REG_STATUS: begin
            res.read_data = {status_r, 5'd0};
            status_nxt[2] = 1'b0;
            second_nxt    = 1'b0;
          end
          vsrt_pkg::REG_SPR_DATA: begin
            spr_req.re = fire;
            res.spr_rd = 1'b1;
          end
          vsrt_pkg::REG_DATA: begin
            res.vram_addr = cur_addr_r[13:0];
            res.vram_read = 1'b1;
            cur_addr_nxt  = addr_step;
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase

    res.fine_x   = fine_nxt;
    res.line_num = line_nxt;
    res.dot_num  = dot_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_addr_r   <= '0;
      tmp_addr_r   <= '0;
      fine_r       <= '0;
      second_r     <= 1'b0;
      ctrl_r       <= '0;
      mask_r       <= '0;
      status_r     <= 3'b101;
      sprite_ptr_r <= '0;
      dot_r        <= '0;
      line_r       <= vsrt_pkg::LINE_LAST;
      odd_r        <= 1'b0;
    end else if (fire) begin
      cur_addr_r   <= cur_addr_nxt;
      tmp_addr_r   <= tmp_addr_nxt;
      fine_r       <= fine_nxt;
      second_r     <= second_nxt;
      ctrl_r       <= ctrl_nxt;
      mask_r       <= mask_nxt;
      status_r     <= status_nxt;
      sprite_ptr_r <= sprite_ptr_nxt;
      dot_r        <= dot_nxt;
      line_r       <= line_nxt;
      odd_r        <= odd_nxt;
    end
  end

  a_dot_range: assert property (@(posedge clk) disable iff (!rst_n)
    dot_r <= vsrt_pkg::DOT_LAST)
    else $error("dot counter out of range");

  a_line_range: assert property (@(posedge clk) disable iff (!rst_n)
    line_r <= vsrt_pkg::LINE_LAST)
    else $error("line counter out of range");

  a_vblank_set: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && cmd == vsrt_pkg::CMD_TICK && line_r == vsrt_pkg::LINE_VBLANK && dot_r == 9'd1)
    |=> status_r[2])
    else $error("vblank flag not set at start of vertical blank");

  a_addr_load: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && cmd == vsrt_pkg::CMD_WRITE && reg_sel == vsrt_pkg::REG_ADDR && second_r)
    |=> (cur_addr_r == {1'b0, tmp_addr_r}) && !second_r)
    else $error("address register second write did not load the current address");

endmodule

`default_nettype wire

### design/video_scroll_register_timing_top.sv
`default_nettype none

// Register file, scroll address logic and frame timing of a tile video unit. Each input
// beat is a dot tick, a register write or a register read, and each one yields exactly one
// result beat carrying the access strobes, the interrupt pulse and the counters after it.
// A new beat is accepted every clock cycle unless output back-pressure stalls it; its
// result is held first in a stage register, beside the registered sprite memory read, and
// then in the output register. The sprite memory keeps a valid bit per byte, so it reads
// as zero after reset without any clearing pass.
module video_scroll_register_timing_top #(
  parameter int SPRITE_BYTES = vsrt_pkg::SPRITE_BYTES
) (
  input wire logic  clk,
  input wire logic  rst_n,
  vsrt_in_if.sink   in_ch,
  vsrt_out_if.source out_ch
);

  logic               fire;
  logic               in_ready;
  logic               s1_move;
  logic               s1_v_r, s1_v_nxt;
  logic               out_v_r, out_v_nxt;
  vsrt_pkg::res_t     ctrl_res;
  vsrt_pkg::res_t     s1_res_r;
  vsrt_pkg::res_t     out_res_r, out_res_nxt;
  vsrt_pkg::spr_req_t spr_req;
  logic [7:0]         spr_rdata;

  assign in_ready    = !s1_v_r || !out_v_r || out_ch.ready;
  assign in_ch.ready = in_ready;
  assign fire        = in_ch.valid && in_ready;
  assign s1_move     = s1_v_r && (!out_v_r || out_ch.ready);

  vsrt_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (fire),
    .cmd     (in_ch.cmd),
    .reg_sel (in_ch.reg_sel),
    .wdata   (in_ch.wdata),
    .res     (ctrl_res),
    .spr_req (spr_req)
  );

  vsrt_spr #(
    .SPRITE_BYTES (SPRITE_BYTES)
  ) u_spr (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (spr_req),
    .rdata (spr_rdata)
  );

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (fire) begin
      s1_v_nxt = 1'b1;
    end else if (s1_move) begin
      s1_v_nxt = 1'b0;
    end

    out_v_nxt = out_v_r;
    if (s1_move) begin
      out_v_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_v_nxt = 1'b0;
    end

    out_res_nxt = s1_res_r;
    if (s1_res_r.spr_rd) begin
      out_res_nxt.read_data = spr_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      s1_res_r <= ctrl_res;
    end
    if (s1_move) begin
      out_res_r <= out_res_nxt;
    end
  end

  assign out_ch.valid      = out_v_r;
  assign out_ch.read_data  = out_res_r.read_data;
  assign out_ch.vram_addr  = out_res_r.vram_addr;
  assign out_ch.vram_write = out_res_r.vram_write;
  assign out_ch.vram_read  = out_res_r.vram_read;
  assign out_ch.vram_wdata = out_res_r.vram_wdata;
  assign out_ch.nmi        = out_res_r.nmi;
  assign out_ch.fine_x     = out_res_r.fine_x;
  assign out_ch.line_num   = out_res_r.line_num;
  assign out_ch.dot_num    = out_res_r.dot_num;

endmodule

`default_nettype wire
